### rtl/core/ptrs_pkg.sv
// shared types and constants for the periodic task release scheduler
// no dependencies
package ptrs_pkg;

  localparam int MAX_TASKS = 16;
  localparam int IDX_W     = $clog2(MAX_TASKS);
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);
  localparam int TIME_W    = 32;
  localparam int PER_W     = 16;
  localparam int TC_W      = 5;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  typedef struct packed {
    logic [PER_W-1:0]  period;
    logic [TIME_W-1:0] due;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } mem_wr_t;

  typedef struct packed {
    logic             re;
    logic [IDX_W-1:0] addr;
  } mem_rd_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
    logic             last;
  } push_t;

  function automatic logic time_reached(logic [TIME_W-1:0] mark, logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] diff;
    diff = now - mark;
    return ~diff[TIME_W-1];
  endfunction

endpackage

### rtl/core/periodic_task_release_scheduler.sv
// periodic task release scheduler top level: config register, sequencer, table, output
// depends on ptrs_pkg, ptrs_table, ptrs_ctrl, ptrs_out
// load beat or tick that starts no round: sequencer stays idle, next beat accepted the cycle after
// tick beat: round scans slots 0 to task_count-1, one slot per cycle unless the output stalls
// first release appears the cycle after the second hit or at round end; output stalls extend it
// reset: round counter, task_count and all enable flags cleared; table contents kept
module periodic_task_release_scheduler
  import ptrs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,  // slot, slot_offset, slot_period, slot_enable, now, zero pad
  input  logic [0:0]  s_tuser,  // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // task_index, zero pad
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata
);

  logic [TC_W-1:0]  task_count;
  mem_wr_t          mem_wr;
  mem_rd_t          mem_rd;
  entry_t           mem_rdata;
  push_t            push;
  logic             out_free;
  logic [IDX_W-1:0] out_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      task_count <= '0;
    end else if (cfg_we) begin
      task_count <= cfg_wdata;
    end
  end

  ptrs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_op      (s_tuser[0]),
    .in_slot    (s_tdata[3:0]),
    .in_offset  (s_tdata[19:4]),
    .in_period  (s_tdata[35:20]),
    .in_enable  (s_tdata[36]),
    .in_now     (s_tdata[68:37]),
    .task_count (task_count),
    .mem_wr     (mem_wr),
    .mem_rd     (mem_rd),
    .mem_rdata  (mem_rdata),
    .out_free   (out_free),
    .push       (push)
  );

  ptrs_table u_table (
    .clk   (clk),
    .wr    (mem_wr),
    .rd    (mem_rd),
    .rdata (mem_rdata)
  );

  ptrs_out u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .idx      (out_idx),
    .last     (m_tlast)
  );

  assign m_tdata = {(8 - IDX_W)'(0), out_idx};

endmodule

### rtl/core/ptrs_table.sv
// slot table memory: period and due time per slot, one write and one read port
// depends on ptrs_pkg
module ptrs_table
  import ptrs_pkg::*;
(
  input  logic    clk,
  input  mem_wr_t wr,
  input  mem_rd_t rd,
  output entry_t  rdata
);

  entry_t mem [MAX_TASKS];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.re) begin
      rdata <= mem[rd.addr];
    end
  end

endmodule

### rtl/core/ptrs_out.sv
// output register for released slot beats
// depends on ptrs_pkg
module ptrs_out
  import ptrs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  push_t            push,
  output logic             free,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [IDX_W-1:0] idx,
  output logic             last
);

  assign free = ~m_tvalid | m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (free) begin
      m_tvalid <= push.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (free && push.valid) begin
      idx  <= push.idx;
      last <= push.last;
    end
  end

endmodule

### rtl/core/ptrs_ctrl.sv
// round sequencer: loads, round counter, enable flags and the slot scan
// depends on ptrs_pkg; drives ptrs_table and ptrs_out
module ptrs_ctrl
  import ptrs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_op,
  input  logic [IDX_W-1:0]  in_slot,
  input  logic [15:0]       in_offset,
  input  logic [PER_W-1:0]  in_period,
  input  logic              in_enable,
  input  logic [TIME_W-1:0] in_now,
  input  logic [TC_W-1:0]   task_count,
  output mem_wr_t           mem_wr,
  output mem_rd_t           mem_rd,
  input  entry_t            mem_rdata,
  input  logic              out_free,
  output push_t             push
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FLUSH} state_t;

  state_t            state;
  logic [TIME_W-1:0] round_time;
  logic [TIME_W-1:0] now_r;
  logic [MAX_TASKS-1:0] enabled;
  logic [CNT_W-1:0]  rd_idx;
  logic [CNT_W-1:0]  limit;
  logic              eval_valid;
  logic [IDX_W-1:0]  eval_idx;
  logic              pend_valid;
  logic [IDX_W-1:0]  pend_idx;

  logic accept;
  logic issue;
  logic hit;
  logic stall;
  logic start_round;
  logic scan_done;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid & in_ready;

  assign start_round = accept && (in_op == OP_TICK)
                       && ({1'b0, task_count} <= (TC_W + 1)'(MAX_TASKS))
                       && time_reached(round_time, in_now);

  assign hit   = eval_valid && enabled[eval_idx] && time_reached(mem_rdata.due, now_r);
  assign stall = hit && pend_valid && !out_free;
  assign issue = (state == S_SCAN) && !stall && (rd_idx < limit);
  assign scan_done = (state == S_SCAN) && !eval_valid && (rd_idx >= limit);

  always_comb begin
    mem_rd.re   = issue;
    mem_rd.addr = rd_idx[IDX_W-1:0];

    mem_wr.we   = 1'b0;
    mem_wr.addr = eval_idx;
    mem_wr.data.period = mem_rdata.period;
    mem_wr.data.due    = mem_rdata.due + TIME_W'(mem_rdata.period);
    if (accept && in_op == OP_LOAD) begin
      mem_wr.we          = 1'b1;
      mem_wr.addr        = in_slot;
      mem_wr.data.period = in_period;
      mem_wr.data.due    = TIME_W'(in_offset);
    end else if (hit && !stall) begin
      mem_wr.we = 1'b1;
    end

    push.valid = 1'b0;
    push.idx   = pend_idx;
    push.last  = 1'b0;
    if (state == S_SCAN && hit && pend_valid && !stall) begin
      push.valid = 1'b1;
    end else if (state == S_FLUSH && pend_valid) begin
      push.valid = 1'b1;
      push.last  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      round_time <= '0;
      enabled    <= '0;
      eval_valid <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && in_op == OP_LOAD) begin
            enabled[in_slot] <= in_enable;
          end
          if (start_round) begin
            round_time <= round_time + 1'b1;
            now_r      <= in_now;
            limit      <= task_count[CNT_W-1:0];
            rd_idx     <= '0;
            eval_valid <= 1'b0;
            pend_valid <= 1'b0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (!stall) begin
            eval_valid <= issue;
            if (issue) begin
              eval_idx <= rd_idx[IDX_W-1:0];
              rd_idx   <= rd_idx + 1'b1;
            end
            if (hit) begin
              pend_valid <= 1'b1;
              pend_idx   <= eval_idx;
            end
          end
          if (scan_done) begin
            state <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (!pend_valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/ptrs_checker.sv
// port-level checks for the periodic task release scheduler
// depends on ptrs_pkg and periodic_task_release_scheduler (bound below)
module ptrs_checker
  import ptrs_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [0:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic        m_tlast
);

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output beat changed while stalled");

  // idle input side stays ready
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready && !s_tvalid |=> s_tready)
    else $error("ready dropped without a beat");

  // a load beat leaves the input ready for the next beat
  a_load_one: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser[0] == OP_LOAD) |=> s_tready)
    else $error("load beat blocked the input");

  // pad bits of the output stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[7:4] == 4'd0)
    else $error("output pad bits not zero");

endmodule

bind periodic_task_release_scheduler ptrs_checker u_ptrs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
